// ===== hw/rtl/hts_pkg.sv =====
// ============================================================================
// hts_pkg
// shared types, widths and codes for the huffman tree stream decoder
// ============================================================================
`default_nettype none

package hts_pkg;

    localparam int TREE_NODES_DEF = 512;  // default size of the node numbering space
    localparam int NODE_BASE      = 256;  // first internal node number
    localparam int SYM_W          = 8;
    localparam int NODE_W         = 9;
    localparam int ID_W           = 10;
    localparam int CNT_W          = 32;
    localparam int KIND_W         = 2;
    localparam int BIT_CNT_W      = 4;

    localparam logic [BIT_CNT_W-1:0] BYTE_BITS = 4'd8;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] ADDR_OUTPUT_LENGTH = 2'd0;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYMBOL        = 2'd0,
        KIND_TREE_OVERFLOW = 2'd1,
        KIND_EARLY_END     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_TREE,
        PH_DECODE,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_BITS,
        SEQ_FINAL,
        SEQ_FLUSH
    } t_seq;

    typedef struct packed {
        t_kind              kind;
        logic [SYM_W-1:0]   sym;
        logic [CNT_W-1:0]   rep;
    } t_result;

    typedef struct packed {
        logic emit;   // new result into the hold stage
        logic flush;  // close the byte: hold stage leaves with run_end set
    } t_buf_ctl;

    typedef struct packed {
        logic room;    // hold stage can take a result this cycle
        logic hold_v;  // a result waits in the hold stage
    } t_buf_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/hts_if.sv =====
// ============================================================================
// hts_if
// valid/ready channels of the decoder: compressed bytes in, results out
// ============================================================================
`default_nettype none

interface hts_strm_if import hts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] stream_byte;
    logic             first_of_stream;
    logic             final_of_stream;

    modport source (output valid, output stream_byte, output first_of_stream,
                    output final_of_stream, input ready);
    modport sink   (input valid, input stream_byte, input first_of_stream,
                    input final_of_stream, output ready);
endinterface

interface hts_res_if import hts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [SYM_W-1:0]  decoded_symbol;
    logic [CNT_W-1:0]  repeat_count;
    logic              run_end;

    modport source (output valid, output result_kind, output decoded_symbol,
                    output repeat_count, output run_end, input ready);
    modport sink   (input valid, input result_kind, input decoded_symbol,
                    input repeat_count, input run_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/huffman_tree_stream_decoder.sv =====
// ============================================================================
// huffman_tree_stream_decoder
// decodes a byte stream that opens with a preorder code tree, one bit a cycle
// ============================================================================
//
// channel  dir  handshake          payload
// -------  ---  -----------------  --------------------------------------------
// i_strm   in   valid/ready        stream_byte, first_of_stream, final_of_stream
// o_res    out  valid/ready        result_kind, decoded_symbol, repeat_count,
//                                  run_end
// apb      in   psel/penable/pwr   output_length at byte address 0x0
//
// a byte is accepted, then runs through its bit steps, a step that closes the
//   bit loop, a further step while the child lookup of the last bit is still
//   in the link table read, a check step on a final byte and a step that
//   closes the byte's results
// the bit loop is set by the link table: each walk step reads one entry and
//   the next address comes straight from that read data
// reset is synchronous, active low; the tables need no clearing pass
// a stalled output stops the bit loop only when a result cannot be placed
//
`default_nettype none

module huffman_tree_stream_decoder import hts_pkg::*; #(
    parameter int TREE_NODES = TREE_NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hts_strm_if.sink          i_strm,
    hts_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // table geometry
    localparam int NS     = TREE_NODES - NODE_BASE;  // internal node entries
    localparam int KW     = $clog2(NS);              // internal node index bits
    localparam int LA     = KW + 1;                  // link address: {node, side}
    localparam int LDEPTH = 2 * NS;
    localparam int SW     = $clog2(2 * NS + 1);      // slot number bits
    localparam int SDEPTH = NS + 1;
    localparam int SAW    = $clog2(NS + 1);
    localparam int DW     = $clog2(NS + 2);          // stack depth bits

    // node inside the internal numbering range
    function automatic logic is_inner(input logic [NODE_W-1:0] p);
        return p[NODE_W-1] && (ID_W'(p) < ID_W'(TREE_NODES));
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_seq                   r_seq,       n_seq;
    t_phase                 r_phase,     n_phase;
    logic [ID_W-1:0]        r_next_id,   n_next_id;
    logic [DW-1:0]          r_depth,     n_depth;
    logic [SW-1:0]          r_tos,       n_tos;     // top of the slot stack
    logic [SYM_W-1:0]       r_lit,       n_lit;
    logic [BIT_CNT_W-1:0]   r_lit_cnt,   n_lit_cnt;
    logic [NODE_W-1:0]      r_root,      n_root;
    logic [NODE_W-1:0]      r_pos,       n_pos;
    logic [CNT_W-1:0]       r_produced,  n_produced;
    logic [SYM_W-1:0]       r_byte,      n_byte;
    logic [BIT_CNT_W-1:0]   r_bit_cnt,   n_bit_cnt;
    logic                   r_final,     n_final;
    logic                   r_pend,      n_pend;    // child lookup in flight
    logic [CNT_W-1:0]       r_out_len;

    // memory ports
    logic                   link_we;
    logic [LA-1:0]          link_waddr;
    logic [NODE_W-1:0]      link_wdata;
    logic                   link_re;
    logic [LA-1:0]          link_raddr;
    logic [NODE_W-1:0]      link_rdata;

    logic                   stk_we;
    logic [SAW-1:0]         stk_waddr;
    logic [SW-1:0]          stk_wdata;
    logic [SAW-1:0]         stk_raddr;
    logic [SW-1:0]          stk_rdata;
    logic [DW-1:0]          depth_next_m2;

    // result path
    t_buf_ctl               buf_ctl;
    t_buf_stat              buf_stat;
    t_result                emit_res;

    // cycle decisions
    logic [SYM_W-1:0]       lit_next;
    logic [NODE_W-1:0]      root_eff;
    logic                   eval_emit;
    logic                   tree_emit;
    logic                   final_emit;
    logic                   emit_req;
    logic                   go;
    logic                   cfg_hit;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    assign cfg_hit = (paddr == ADDR_OUTPUT_LENGTH);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? r_out_len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len <= '0;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_out_len <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    hts_link_ram #(
        .DEPTH (LDEPTH),
        .AW    (LA)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // the entry just below the top is always staged, so a pop needs no wait
    assign depth_next_m2 = n_depth - DW'(2);
    assign stk_raddr     = depth_next_m2[SAW-1:0];

    hts_stack_ram #(
        .WIDTH (SW),
        .DEPTH (SDEPTH),
        .AW    (SAW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    hts_result_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (buf_ctl),
        .i_res   (emit_res),
        .o_stat  (buf_stat),
        .o_res   (o_res)
    );

    // ------------------------------------------------------------------
    // will this cycle place a result; stall the whole step if it cannot
    // ------------------------------------------------------------------
    assign lit_next  = {r_lit[SYM_W-2:0], r_byte[SYM_W-1]};
    // root as it stands after a literal fills the popped slot
    assign root_eff  = (r_tos == '0) ? {1'b0, lit_next} : r_root;

    assign eval_emit = r_pend && !link_rdata[NODE_W-1];

    assign tree_emit = (r_phase == PH_TREE) && (r_bit_cnt != '0) &&
                       (((r_lit_cnt == BIT_CNT_W'(1)) && (r_depth == DW'(1)) &&
                         !root_eff[NODE_W-1] && (r_produced < r_out_len)) ||
                        ((r_lit_cnt == '0) && r_byte[SYM_W-1] &&
                         (r_next_id >= ID_W'(TREE_NODES))));

    assign final_emit = (r_phase == PH_TREE) ||
                        ((r_phase == PH_DECODE) && (r_produced < r_out_len));

    assign emit_req = ((r_seq == SEQ_BITS) && (eval_emit || tree_emit)) ||
                      ((r_seq == SEQ_FINAL) && final_emit);
    assign go       = !emit_req || buf_stat.room;

    // ------------------------------------------------------------------
    // bit engine and byte sequencer
    // ------------------------------------------------------------------
    always_comb begin : p_next
        logic               bit_in;
        t_phase             ph;
        logic [NODE_W-1:0]  pos;
        logic [CNT_W-1:0]   prod;
        logic [KW-1:0]      new_k;
        logic [SW-1:0]      slot_m1;
        logic [DW-1:0]      depth_m1;

        bit_in   = r_byte[SYM_W-1];
        ph       = r_phase;
        pos      = r_pos;
        prod     = r_produced;
        new_k    = r_next_id[KW-1:0];
        slot_m1  = r_tos - SW'(1);
        depth_m1 = r_depth - DW'(1);

        n_seq      = r_seq;
        n_phase    = r_phase;
        n_next_id  = r_next_id;
        n_depth    = r_depth;
        n_tos      = r_tos;
        n_lit      = r_lit;
        n_lit_cnt  = r_lit_cnt;
        n_root     = r_root;
        n_pos      = r_pos;
        n_produced = r_produced;
        n_byte     = r_byte;
        n_bit_cnt  = r_bit_cnt;
        n_final    = r_final;
        n_pend     = r_pend;

        i_strm.ready = 1'b0;
        link_we      = 1'b0;
        link_waddr   = '0;
        link_wdata   = '0;
        link_re      = 1'b0;
        link_raddr   = '0;
        stk_we       = 1'b0;
        stk_waddr    = '0;
        stk_wdata    = '0;
        buf_ctl      = '0;
        emit_res     = '{kind: KIND_SYMBOL, sym: '0, rep: '0};

        unique case (r_seq)
            SEQ_IDLE: begin
                i_strm.ready = 1'b1;
                if (i_strm.valid) begin
                    n_byte    = i_strm.stream_byte;
                    n_bit_cnt = BYTE_BITS;
                    n_final   = i_strm.final_of_stream;
                    n_seq     = SEQ_BITS;
                    // new stream: empty tree, root slot pending
                    if (i_strm.first_of_stream) begin
                        n_phase    = PH_TREE;
                        n_next_id  = ID_W'(NODE_BASE);
                        n_depth    = DW'(1);
                        n_tos      = '0;
                        n_lit      = '0;
                        n_lit_cnt  = '0;
                        n_root     = '0;
                        n_pos      = '0;
                        n_produced = '0;
                    end
                end
            end

            SEQ_BITS: begin
                if (go) begin
                    // finish the lookup of the previous bit
                    if (r_pend) begin
                        n_pend = 1'b0;
                        if (!link_rdata[NODE_W-1]) begin
                            buf_ctl.emit = 1'b1;
                            emit_res     = '{kind: KIND_SYMBOL,
                                             sym:  link_rdata[SYM_W-1:0],
                                             rep:  CNT_W'(1)};
                            prod = r_produced + CNT_W'(1);
                            pos  = r_root;
                            if (prod >= r_out_len) begin
                                ph = PH_DONE;
                            end
                        end else begin
                            pos = link_rdata;
                        end
                    end

                    if (r_bit_cnt != '0) begin
                        n_bit_cnt = r_bit_cnt - BIT_CNT_W'(1);
                        n_byte    = {r_byte[SYM_W-2:0], 1'b0};
                        unique case (ph)
                            PH_TREE: begin
                                if (r_lit_cnt != '0) begin
                                    n_lit     = lit_next;
                                    n_lit_cnt = r_lit_cnt - BIT_CNT_W'(1);
                                    if (r_lit_cnt == BIT_CNT_W'(1)) begin
                                        // leaf fills the slot on top
                                        if (r_tos == '0) begin
                                            n_root = {1'b0, lit_next};
                                        end else begin
                                            link_we    = 1'b1;
                                            link_waddr = slot_m1[LA-1:0];
                                            link_wdata = {1'b0, lit_next};
                                        end
                                        n_depth = depth_m1;
                                        n_tos   = stk_rdata;
                                        if (r_depth == DW'(1)) begin
                                            // last slot filled: tree done
                                            pos = root_eff;
                                            if (prod >= r_out_len) begin
                                                ph = PH_DONE;
                                            end else if (!root_eff[NODE_W-1]) begin
                                                buf_ctl.emit = 1'b1;
                                                emit_res = '{kind: KIND_SYMBOL,
                                                             sym:  root_eff[SYM_W-1:0],
                                                             rep:  r_out_len - prod};
                                                prod = r_out_len;
                                                ph   = PH_DONE;
                                            end else begin
                                                ph = PH_DECODE;
                                            end
                                        end
                                    end
                                end else if (bit_in) begin
                                    if (r_next_id >= ID_W'(TREE_NODES)) begin
                                        buf_ctl.emit = 1'b1;
                                        emit_res     = '{kind: KIND_TREE_OVERFLOW,
                                                         sym:  '0,
                                                         rep:  '0};
                                        ph = PH_ERROR;
                                    end else begin
                                        // new internal node takes the top slot,
                                        // then its right and left slots go on
                                        n_next_id = r_next_id + ID_W'(1);
                                        if (r_tos == '0) begin
                                            n_root = r_next_id[NODE_W-1:0];
                                        end else begin
                                            link_we    = 1'b1;
                                            link_waddr = slot_m1[LA-1:0];
                                            link_wdata = r_next_id[NODE_W-1:0];
                                        end
                                        stk_we    = 1'b1;
                                        stk_waddr = depth_m1[SAW-1:0];
                                        stk_wdata = SW'({new_k, 1'b0}) + SW'(2);
                                        n_tos     = SW'({new_k, 1'b1});
                                        n_depth   = r_depth + DW'(1);
                                    end
                                end else begin
                                    n_lit     = '0;
                                    n_lit_cnt = BYTE_BITS;
                                end
                            end

                            PH_DECODE: begin
                                if (prod >= r_out_len) begin
                                    ph = PH_DONE;
                                end else begin
                                    if (!is_inner(pos)) begin
                                        pos = r_root;
                                    end
                                    if (!is_inner(pos)) begin
                                        ph = PH_DONE;
                                    end else begin
                                        link_re    = 1'b1;
                                        link_raddr = {pos[KW-1:0], bit_in};
                                        n_pend     = 1'b1;
                                    end
                                end
                            end

                            PH_DONE, PH_ERROR: begin
                                // bits pass without effect
                            end
                        endcase
                    end else if (!r_pend) begin
                        n_seq = r_final ? SEQ_FINAL : SEQ_FLUSH;
                    end

                    n_phase    = ph;
                    n_pos      = pos;
                    n_produced = prod;
                end
            end

            SEQ_FINAL: begin
                if (go) begin
                    if (final_emit) begin
                        buf_ctl.emit = 1'b1;
                        emit_res     = '{kind: KIND_EARLY_END, sym: '0, rep: '0};
                    end
                    if (r_phase != PH_ERROR) begin
                        n_phase = PH_DONE;
                    end
                    n_seq = SEQ_FLUSH;
                end
            end

            SEQ_FLUSH: begin
                // last result of the byte leaves with run_end set
                buf_ctl.flush = buf_stat.hold_v;
                if (buf_stat.room) begin
                    n_seq = SEQ_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SEQ_IDLE;
            r_phase    <= PH_TREE;
            r_next_id  <= ID_W'(NODE_BASE);
            r_depth    <= DW'(1);
            r_tos      <= '0;
            r_lit      <= '0;
            r_lit_cnt  <= '0;
            r_root     <= '0;
            r_pos      <= '0;
            r_produced <= '0;
            r_bit_cnt  <= '0;
            r_final    <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_phase    <= n_phase;
            r_next_id  <= n_next_id;
            r_depth    <= n_depth;
            r_tos      <= n_tos;
            r_lit      <= n_lit;
            r_lit_cnt  <= n_lit_cnt;
            r_root     <= n_root;
            r_pos      <= n_pos;
            r_produced <= n_produced;
            r_bit_cnt  <= n_bit_cnt;
            r_final    <= n_final;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(NS + 1))
        else $error("slot stack deeper than the node table allows");

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_seq == SEQ_BITS) && (r_phase == PH_DECODE))
        else $error("child lookup pending outside the walk");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_ctl.emit |-> buf_stat.room)
        else $error("result placed while the hold stage is blocked");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strm.valid && i_strm.ready) |=>
            (r_seq == SEQ_BITS) && (r_bit_cnt == BYTE_BITS))
        else $error("accepted byte did not start the bit loop");

endmodule

`default_nettype wire

// ===== hw/rtl/hts_link_ram.sv =====
// ============================================================================
// hts_link_ram
// child link table, one entry per (node, side), registered read
// ============================================================================
`default_nettype none

module hts_link_ram import hts_pkg::*; #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [NODE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [NODE_W-1:0] o_rdata
);

    logic [NODE_W-1:0] mem [DEPTH];
    logic [NODE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // read data holds while no lookup is issued
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/hts_stack_ram.sv =====
// ============================================================================
// hts_stack_ram
// pending slot stack below the top entry, read every cycle, write forwarded
// ============================================================================
`default_nettype none

module hts_stack_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 257,
    parameter int AW    = 9
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // same-entry write wins over the stored value
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/hts_result_buf.sv =====
// ============================================================================
// hts_result_buf
// hold stage plus output register; run_end is known once the next result
// or the end of the byte arrives
// ============================================================================
`default_nettype none

module hts_result_buf import hts_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_buf_ctl      i_ctl,
    input  t_result       i_res,
    output t_buf_stat     o_stat,
    hts_res_if.source     o_res
);

    logic    r_hold_v;
    t_result r_hold;
    logic    r_out_v;
    t_result r_out;
    logic    r_out_end;
    logic    out_free;
    logic    load_out;

    assign out_free = !r_out_v || o_res.ready;
    assign load_out = r_hold_v && out_free && (i_ctl.emit || i_ctl.flush);

    assign o_stat.room   = !r_hold_v || out_free;
    assign o_stat.hold_v = r_hold_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            if (i_ctl.emit) begin
                r_hold_v <= 1'b1;
            end else if (i_ctl.flush && out_free) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out     <= r_hold;
            r_out_end <= i_ctl.flush;
        end
        if (i_ctl.emit) begin
            r_hold <= i_res;
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.result_kind    = r_out.kind;
    assign o_res.decoded_symbol = r_out.sym;
    assign o_res.repeat_count   = r_out.rep;
    assign o_res.run_end        = r_out_end;

endmodule

`default_nettype wire

// ===== test/huffman_tree_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// huffman_tree_stream_decoder_tb
// self-checking bench: builds code trees and packed bit streams, predicts every
// decoded result in a scoreboard and checks the result channel transfer by
// transfer under random idling on both channels
// ============================================================================

import hts_pkg::*;

localparam int NODE_LIMIT  = TREE_NODES_DEF;
localparam int NODE_SLOTS  = NODE_LIMIT - NODE_BASE;
localparam int STACK_SLOTS = NODE_SLOTS + 1;

typedef struct {
    t_kind            kind;
    logic [SYM_W-1:0] sym;
    logic [CNT_W-1:0] rep;
    logic             run_end;
} t_decoded_result;

typedef struct {
    logic [SYM_W-1:0] data;
    logic             first_flag;
    logic             final_flag;
} t_stream_item;

class decode_scoreboard;
    logic [NODE_W-1:0] left_child [NODE_SLOTS];
    logic [NODE_W-1:0] right_child [NODE_SLOTS];
    logic [ID_W-1:0]   slot_stack [STACK_SLOTS];
    logic [ID_W-1:0]   next_node;
    int                stack_level;
    t_phase            phase;
    logic [SYM_W-1:0]  literal;
    int                literal_left;
    logic [NODE_W-1:0] root_node;
    logic [NODE_W-1:0] walk_node;
    logic [CNT_W-1:0]  produced;
    logic [CNT_W-1:0]  out_length;
    t_decoded_result   expected_results[$];
    t_decoded_result   byte_results[$];
    int                mismatches;
    int                checked;

    function new();
        mismatches = 0;
        checked    = 0;
        out_length = '0;
        clear_state();
    endfunction

    function void clear_state();
        foreach (left_child[i]) begin
            left_child[i]  = '0;
            right_child[i] = '0;
        end
        foreach (slot_stack[i]) slot_stack[i] = '0;
        next_node    = ID_W'(NODE_BASE);
        stack_level  = 1;
        phase        = PH_TREE;
        literal      = '0;
        literal_left = 0;
        root_node    = '0;
        walk_node    = '0;
        produced     = '0;
    endfunction

    function void emit(t_kind kind, logic [SYM_W-1:0] sym, logic [CNT_W-1:0] rep);
        t_decoded_result r;
        r.kind    = kind;
        r.sym     = sym;
        r.rep     = rep;
        r.run_end = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    function int take_slot();
        if (stack_level == 0) return 0;
        stack_level--;
        return slot_stack[stack_level];
    endfunction

    function void put_slot(int slot);
        if (stack_level < STACK_SLOTS) begin
            slot_stack[stack_level] = ID_W'(slot);
            stack_level++;
        end
    endfunction

    // slot 0 is the root, slot 1 + 2k + side is a child of node 256 + k
    function void link_slot(int slot, int value);
        int k;
        if (slot == 0) begin
            root_node = NODE_W'(value);
        end else begin
            k = (slot - 1) >> 1;
            if (k < NODE_SLOTS) begin
                if ((slot - 1) % 2 == 1) right_child[k] = NODE_W'(value);
                else left_child[k] = NODE_W'(value);
            end
        end
    endfunction

    function void accept_byte(logic [SYM_W-1:0] data, logic first, logic last);
        int                node;
        int                k;
        logic              bit_in;
        logic [NODE_W-1:0] child;
        byte_results.delete();
        if (first) clear_state();
        for (int i = SYM_W - 1; i >= 0; i--) begin
            bit_in = data[i];
            if (phase == PH_TREE) begin
                if (literal_left != 0) begin
                    literal = {literal[SYM_W-2:0], bit_in};
                    literal_left--;
                    if (literal_left == 0) begin
                        link_slot(take_slot(), literal);
                        if (stack_level == 0) begin
                            walk_node = root_node;
                            if (produced >= out_length) begin
                                phase = PH_DONE;
                            end else if (root_node < NODE_BASE) begin
                                // lone leaf carries the whole remainder at once
                                emit(KIND_SYMBOL, root_node[SYM_W-1:0], out_length - produced);
                                produced = out_length;
                                phase    = PH_DONE;
                            end else begin
                                phase = PH_DECODE;
                            end
                        end
                    end
                end else if (bit_in) begin
                    node = next_node;
                    if (node >= NODE_LIMIT) begin
                        emit(KIND_TREE_OVERFLOW, '0, '0);
                        phase = PH_ERROR;
                    end else begin
                        next_node++;
                        link_slot(take_slot(), node);
                        put_slot(2 + 2 * (node - NODE_BASE));
                        put_slot(1 + 2 * (node - NODE_BASE));
                    end
                end else begin
                    literal      = '0;
                    literal_left = BYTE_BITS;
                end
            end else if (phase == PH_DECODE) begin
                if (produced >= out_length) begin
                    phase = PH_DONE;
                end else begin
                    if (walk_node < NODE_BASE || walk_node - NODE_BASE >= NODE_SLOTS)
                        walk_node = root_node;
                    if (walk_node < NODE_BASE || walk_node - NODE_BASE >= NODE_SLOTS) begin
                        phase = PH_DONE;
                    end else begin
                        k     = walk_node - NODE_BASE;
                        child = bit_in ? right_child[k] : left_child[k];
                        if (child < NODE_BASE) begin
                            emit(KIND_SYMBOL, child[SYM_W-1:0], 32'd1);
                            produced++;
                            walk_node = root_node;
                            if (produced >= out_length) phase = PH_DONE;
                        end else begin
                            walk_node = child;
                        end
                    end
                end
            end
        end
        if (last) begin
            if (phase == PH_TREE || (phase == PH_DECODE && produced < out_length))
                emit(KIND_EARLY_END, '0, '0);
            if (phase != PH_ERROR) phase = PH_DONE;
        end
        if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_end = 1'b1;
        foreach (byte_results[i]) expected_results = {expected_results, byte_results[i]};
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    task report(string what);
        if (mismatches < 30) $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task check(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym, logic [CNT_W-1:0] rep,
               logic run_end);
        t_decoded_result want;
        if (expected_results.size() == 0) begin
            report($sformatf("result kind %0d sym %0d with nothing outstanding", kind, sym));
        end else begin
            want = expected_results.pop_front();
            if (kind !== want.kind)
                report($sformatf("result %0d kind %0d, wanted %0d", checked, kind, want.kind));
            if (sym !== want.sym)
                report($sformatf("result %0d symbol %0d, wanted %0d", checked, sym, want.sym));
            if (rep !== want.rep)
                report($sformatf("result %0d repeat %0d, wanted %0d", checked, rep, want.rep));
            if (run_end !== want.run_end)
                report($sformatf("result %0d run_end %0b, wanted %0b", checked, run_end,
                                 want.run_end));
        end
        checked++;
    endtask
endclass

module huffman_tree_stream_decoder_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 48;    // longer than a byte needs inside the block
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
    localparam int LONG_HOLD      = 300;   // receiver stall that backs up the input
    localparam int PHASE_ITEMS    = 52;
    localparam int MAX_CODE_LEN   = 12;
    localparam int OVERFLOW_BYTES = 33;    // 264 one bits, node 512 is reached in the last

    logic clk = 1'b0;
    logic rst_n;

    hts_strm_if strm ();
    hts_res_if  res ();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    decode_scoreboard sb = new();

    int           snd_idle_pct;
    int           rcv_idle_pct;
    int           hold_cycles  = 0;
    int           items_sent   = 0;
    int           quiet_cycles = 0;
    t_stream_item byte_plan[$];

    huffman_tree_stream_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_strm  (strm),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // -------------------------------------------------------------------------
    // apb: write output_length, read it back, then update the predictor copy
    // -------------------------------------------------------------------------
    task automatic write_length(logic [CNT_W-1:0] value);
        logic [APB_DW-1:0] readback;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_OUTPUT_LENGTH;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        // read setup follows straight on, psel stays high
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
            sb.report($sformatf("output_length reads %0h, written %0h", readback, value));
        sb.out_length = value;
    endtask

    // -------------------------------------------------------------------------
    // byte channel: random idle gaps, then hold the byte until its transfer
    // -------------------------------------------------------------------------
    task automatic send_byte(logic [SYM_W-1:0] data, logic first, logic last);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            strm.valid <= 1'b0;
            @(negedge clk);
        end
        strm.valid           <= 1'b1;
        strm.stream_byte     <= data;
        strm.first_of_stream <= first;
        strm.final_of_stream <= last;
        do @(posedge clk); while (strm.ready !== 1'b1);
        sb.accept_byte(data, first, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_plan(int count);
        t_stream_item item;
        repeat (count) begin
            if (byte_plan.size() > 0) begin
                item = byte_plan.pop_front();
                send_byte(item.data, item.first_flag, item.final_flag);
            end
        end
    endtask

    // sender stops until every outstanding result is in, then lets the block settle
    task automatic wait_idle();
        strm.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // -------------------------------------------------------------------------
    // stream builder: random code tree in preorder, then codes of random leaves,
    // packed msb first and padded with random bits to whole bytes
    // -------------------------------------------------------------------------
    task automatic build_stream(int leaves, int symbols, bit truncate, logic first,
                                logic last);
        int           open_leaves[$];
        logic [31:0]  open_path[$];
        int           open_depth[$];
        bit           bits[$];
        logic [31:0]  leaf_code[$];
        int           leaf_len[$];
        int           n;
        int           d;
        int           split;
        int           pick;
        logic [31:0]  p;
        logic [SYM_W-1:0] s;
        t_stream_item item;
        open_leaves = {open_leaves, leaves};
        open_path   = {open_path, 32'd0};
        open_depth  = {open_depth, 0};
        // newest open subtree first, left child pushed last so it comes out first
        while (open_leaves.size() > 0) begin
            n = open_leaves.pop_back();
            p = open_path.pop_back();
            d = open_depth.pop_back();
            if (n <= 1 || d >= MAX_CODE_LEN) begin
                s = $urandom;
                bits = {bits, 1'b0};
                for (int i = SYM_W - 1; i >= 0; i--) bits = {bits, bit'(s[i])};
                leaf_code = {leaf_code, p};
                leaf_len  = {leaf_len, d};
            end else begin
                split = $urandom_range(1, n - 1);
                bits        = {bits, 1'b1};
                open_leaves = {open_leaves, n - split};
                open_path   = {open_path, {p[30:0], 1'b1}};
                open_depth  = {open_depth, d + 1};
                open_leaves = {open_leaves, split};
                open_path   = {open_path, {p[30:0], 1'b0}};
                open_depth  = {open_depth, d + 1};
            end
        end
        // a lone leaf needs no code bits at all
        if (leaf_len.size() > 1) begin
            repeat (symbols) begin
                pick = $urandom_range(0, leaf_len.size() - 1);
                for (int i = leaf_len[pick] - 1; i >= 0; i--)
                    bits = {bits, bit'(leaf_code[pick][i])};
            end
        end
        if (truncate) begin
            pick = $urandom_range(0, bits.size() - 1);
            while (bits.size() > pick) void'(bits.pop_back());
        end
        while (bits.size() == 0 || bits.size() % 8 != 0) bits = {bits, 1'($urandom)};
        for (int i = 0; i < bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++) item.data[7-j] = bits[i+j];
            item.first_flag = first && (i == 0);
            item.final_flag = last && (i + 8 == bits.size());
            byte_plan = {byte_plan, item};
        end
    endtask

    // -------------------------------------------------------------------------
    // result side: random back-pressure, plus a long hold when asked for
    // -------------------------------------------------------------------------
    initial begin : receiver
        res.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                res.ready <= 1'b0;
                hold_cycles--;
            end else begin
                res.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge clk) begin
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
            sb.check(res.result_kind, res.decoded_symbol, res.repeat_count, res.run_end);
    end

    // watchdog: too long without a transfer on either channel ends the run
    always @(posedge clk) begin
        if ((strm.valid === 1'b1 && strm.ready === 1'b1) ||
            (res.valid === 1'b1 && res.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -------------------------------------------------------------------------
    // stimulus
    // -------------------------------------------------------------------------
    initial begin : stimulus
        logic [CNT_W-1:0] length_sel;
        t_stream_item     item;
        int               start_items;
        int               pick;
        int               leaves;
        int               symbols;

        rst_n                = 1'b0;
        strm.valid           = 1'b0;
        strm.stream_byte     = '0;
        strm.first_of_stream = 1'b0;
        strm.final_of_stream = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        snd_idle_pct         = 10;
        rcv_idle_pct         = 53;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        write_length(32'd3);
        // reset already starts tree reading, no first flag needed
        build_stream(3, 3, 1'b0, 1'b0, 1'b1);
        send_plan(byte_plan.size());
        // lone leaf 0xff, then lone leaf 0x00: one result with the full count
        send_byte(8'h7F, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // stream ends while the tree is still open
        send_byte(8'hFF, 1'b1, 1'b1);

        // zero output length: tree closes and nothing comes out
        wait_idle();
        write_length(32'd0);
        build_stream(4, 2, 1'b0, 1'b1, 1'b1);
        send_plan(byte_plan.size());

        // largest length: lone leaf repeat, then a stream that ends while decoding
        wait_idle();
        write_length(32'hFFFF_FFFF);
        build_stream(1, 0, 1'b0, 1'b1, 1'b1);
        send_plan(byte_plan.size());
        build_stream(5, 4, 1'b0, 1'b1, 1'b1);
        send_plan(byte_plan.size());

        // length lowered below the count already produced ends the stream
        wait_idle();
        write_length(32'd8);
        build_stream(2, 8, 1'b0, 1'b1, 1'b1);
        send_plan(3);
        wait_idle();
        write_length(32'd1);
        send_plan(byte_plan.size());

        // ---- random part, one output length per phase ----
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                snd_idle_pct = 10;
                rcv_idle_pct = 53;
            end else if (ph < 6) begin
                snd_idle_pct = 53;
                rcv_idle_pct = 10;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            wait_idle();
            case (ph)
                0:       length_sel = 32'd1;
                1:       length_sel = 32'd0;
                2:       length_sel = 32'hFFFF_FFFF;
                3:       length_sel = $urandom_range(2, 12);
                4:       length_sel = $urandom_range(5, 24);
                5:       length_sel = 32'd3;
                6:       length_sel = $urandom_range(1, 16);
                default: length_sel = $urandom_range(8, 40);
            endcase
            write_length(length_sel);

            // all-ones tree runs past the node table
            if (ph == 1 || ph == 5) begin
                for (int i = 0; i < OVERFLOW_BYTES; i++) begin
                    item.data       = 8'hFF;
                    item.first_flag = (i == 0);
                    item.final_flag = (i == OVERFLOW_BYTES - 1);
                    byte_plan = {byte_plan, item};
                end
                send_plan(byte_plan.size());
            end

            // receiver stalls for a long stretch while bytes keep coming
            if (ph == 6) hold_cycles = LONG_HOLD;

            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) leaves = 1;
                else if (pick < 97) leaves = $urandom_range(2, 16);
                else leaves = $urandom_range(30, 64);
                if (sb.out_length <= 16) symbols = sb.out_length;
                else symbols = $urandom_range(1, 12);

                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    // well-formed, mostly with the first flag, final flag at random
                    build_stream(leaves, symbols, 1'b0, $urandom_range(0, 99) < 96,
                                 $urandom_range(0, 99) < 60);
                end else if (pick < 86) begin
                    // cut short anywhere, closed by the final flag
                    build_stream(leaves, symbols, 1'b1, 1'b1, 1'b1);
                end else begin
                    // noise bytes with random flags
                    repeat ($urandom_range(1, 5)) begin
                        item.data       = $urandom;
                        item.first_flag = $urandom_range(0, 1);
                        item.final_flag = ($urandom_range(0, 3) == 0);
                        byte_plan = {byte_plan, item};
                    end
                end
                send_plan(byte_plan.size());
            end
        end

        wait_idle();
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
